@@ rtl/least_loaded_owner_assigner_assert.svh @@
// Assertion macros shared by the checker of the least-loaded owner assigner.
`ifndef LEAST_LOADED_OWNER_ASSIGNER_ASSERT_SVH
`define LEAST_LOADED_OWNER_ASSIGNER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LLOA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LLOA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lloa_pkg.sv @@
// Constants, types and status codes of the least-loaded owner assigner.
`default_nettype none
package lloa_pkg;

	localparam int MAX_LAYERS = 4;
	localparam int MAX_OWNERS = 16;
	localparam int LOAD_BITS  = 40;
	localparam int LANES      = 4;
	localparam int SLOTS      = MAX_OWNERS / LANES;

	localparam int OWNER_W  = $clog2(MAX_OWNERS);
	localparam int LANE_W   = $clog2(LANES);
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int CFG_W    = 5;
	localparam int COUNT_W  = 20;
	localparam int LEVEL_W  = 3;
	localparam int LVL_W    = 2;
	localparam int TOTAL_W  = COUNT_W + $clog2(MAX_LAYERS);
	localparam int SUM_W    = LOAD_BITS + 1;
	localparam int RANK_W   = 5;
	localparam int OFFSET_W = 41;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd2;

	// Best owner found so far by a lane or by the merge tree
	typedef struct packed {
		logic                 found;
		logic [OWNER_W-1:0]   idx;
		logic [LOAD_BITS-1:0] load;
	} lloa_cand_t;

	// Load update broadcast to all lanes
	typedef struct packed {
		logic                 en;
		logic [OWNER_W-1:0]   idx;
		logic [LOAD_BITS-1:0] data;
	} lloa_wr_t;

endpackage
`default_nettype wire

@@ rtl/lloa_if.sv @@
// Valid/ready channel interfaces for surface words and result words.
`default_nettype none
interface lloa_item_if;
	import lloa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 batch_start;
	logic                 is_retired;
	logic [LEVEL_W-1:0]   level_count;
	logic [COUNT_W-1:0]   layer0_count;
	logic [COUNT_W-1:0]   layer1_count;
	logic [COUNT_W-1:0]   layer2_count;
	logic [COUNT_W-1:0]   layer3_count;

	modport source (
		output valid, batch_start, is_retired, level_count,
		output layer0_count, layer1_count, layer2_count, layer3_count,
		input  ready
	);
	modport sink (
		input  valid, batch_start, is_retired, level_count,
		input  layer0_count, layer1_count, layer2_count, layer3_count,
		output ready
	);
endinterface

interface lloa_result_if;
	import lloa_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [RANK_W-1:0]    owner_rank;
	logic signed [OFFSET_W-1:0]  layer_offset;
	logic [LVL_W-1:0]            level_index;
	logic                        is_last;
	logic [STATUS_W-1:0]         status;

	modport source (
		output valid, owner_rank, layer_offset, level_index, is_last, status,
		input  ready
	);
	modport sink (
		input  valid, owner_rank, layer_offset, level_index, is_last, status,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/least_loaded_owner_assigner.sv @@
// Top level: greedy least-loaded owner assignment of surfaces and layer offsets.
`default_nettype none
// Each accepted surface word goes to the owner with the smallest running load
// (ties to the lowest index) among the first owner_count owners, and yields one
// result word per layer with the owner and the layer's start offset, then the
// surface total is added to that owner's load. A retired surface, bad layer
// data or a load that would overflow yields a single word with owner and offset
// of -1. Four lanes each scan four owner loads, one per cycle, and a two-level
// registered tree merges them; the winner is then checked for overflow before
// the layer words are handed out, while a retired or invalid surface goes
// straight to its single word. One surface is in flight at a time; the
// next is taken once the last result word sits in the output register. Write
// owner_count only while no surface is in flight.
module least_loaded_owner_assigner (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [lloa_pkg::CFG_W-1:0] cfg_wdata,
	lloa_item_if.sink                       item,
	lloa_result_if.source                   result
);
	import lloa_pkg::*;

	localparam int WAIT_END = SLOTS + 1;
	localparam int WAIT_W   = $clog2(WAIT_END + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WAIT  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_NONE  = 3'd4;

	logic [2:0]           state_q;
	logic [WAIT_W-1:0]    wait_q;
	logic [CFG_W-1:0]     owner_count_q;
	logic [CFG_W-1:0]     owners_eff;

	logic [COUNT_W-1:0]   layer_in [MAX_LAYERS];
	logic                 levels_ok;
	logic                 counts_ok;
	logic [TOTAL_W-1:0]   total_in;
	logic                 accept;
	logic                 clear;
	logic                 scan_start;

	logic [LEVEL_W-1:0]   levels_q;
	logic [COUNT_W-1:0]   cnt_q [MAX_LAYERS];
	logic [TOTAL_W-1:0]   total_q;
	logic [STATUS_W-1:0]  none_status_q;
	logic [OWNER_W-1:0]   owner_q;
	logic [LOAD_BITS-1:0] offset_q;
	logic [LOAD_BITS-1:0] new_load_q;
	logic [LVL_W-1:0]     lvl_q;
	logic                 wr_en_q;

	lloa_cand_t           lane_best [LANES];
	lloa_cand_t           best;
	lloa_wr_t             wr;
	logic [SUM_W-1:0]     sum_check;
	logic                 overflow;

	logic                 slot_free;
	logic                 load_emit;
	logic                 load_none;
	logic                 emit_last;

	logic                        res_valid_q;
	logic signed [RANK_W-1:0]    res_owner_q;
	logic signed [OFFSET_W-1:0]  res_offset_q;
	logic [LVL_W-1:0]            res_level_q;
	logic                        res_last_q;
	logic [STATUS_W-1:0]         res_status_q;

	// Owner count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_count_q <= CFG_W'(1);
		end else if (cfg_we) begin
			owner_count_q <= cfg_wdata;
		end
	end

	// Zero acts as one owner, anything above the table as the full table
	always_comb begin
		if (owner_count_q == '0) owners_eff = CFG_W'(1);
		else if (owner_count_q > CFG_W'(MAX_OWNERS)) owners_eff = CFG_W'(MAX_OWNERS);
		else owners_eff = owner_count_q;
	end

	// Check the incoming layer data and sum the used layers
	assign layer_in[0] = item.layer0_count;
	assign layer_in[1] = item.layer1_count;
	assign layer_in[2] = item.layer2_count;
	assign layer_in[3] = item.layer3_count;

	always_comb begin
		levels_ok = (item.level_count != '0) &&
			(item.level_count <= LEVEL_W'(MAX_LAYERS));
		counts_ok = 1'b1;
		total_in  = '0;
		for (int i = 0; i < MAX_LAYERS; i++) begin
			if (LEVEL_W'(i) < item.level_count) begin
				if (layer_in[i] == '0) counts_ok = 1'b0;
				total_in = total_in + TOTAL_W'(layer_in[i]);
			end
		end
	end

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign clear      = accept && item.batch_start;
	assign scan_start = accept && !item.is_retired && levels_ok && counts_ok;

	// Scan lanes and merge tree
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		lloa_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.lane_id    (LANE_W'(g)),
			.clear      (clear),
			.scan_start (scan_start),
			.owners     (owners_eff),
			.wr         (wr),
			.best       (lane_best[g])
		);
	end

	lloa_merge u_merge (
		.clk       (clk),
		.lane_best (lane_best),
		.best      (best)
	);

	assign wr = '{en: wr_en_q, idx: owner_q, data: new_load_q};

	assign sum_check = {1'b0, best.load} + SUM_W'(total_q);
	assign overflow  = sum_check[SUM_W-1];

	assign slot_free = !res_valid_q || result.ready;
	assign load_emit = (state_q == ST_EMIT) && slot_free;
	assign load_none = (state_q == ST_NONE) && slot_free;
	assign emit_last = (LEVEL_W'(lvl_q) + LEVEL_W'(1)) == levels_q;

	// Sequencer: scan, check, then hand out one word per layer or a single reject word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= '0;
			wr_en_q <= 1'b0;
		end else begin
			wr_en_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wait_q  <= '0;
						state_q <= scan_start ? ST_WAIT : ST_NONE;
					end
				end
				ST_WAIT: begin
					wait_q <= wait_q + WAIT_W'(1);
					if (wait_q == WAIT_W'(WAIT_END)) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= overflow ? ST_NONE : ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free && emit_last) begin
						wr_en_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_NONE: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item data, winner and running offset
	always_ff @(posedge clk) begin
		if (accept) begin
			levels_q      <= item.level_count;
			cnt_q         <= layer_in;
			total_q       <= total_in;
			none_status_q <= item.is_retired ? STATUS_OK : STATUS_INVALID;
		end
		if (state_q == ST_CHECK) begin
			owner_q    <= best.idx;
			offset_q   <= best.load;
			new_load_q <= sum_check[LOAD_BITS-1:0];
			lvl_q      <= '0;
			if (overflow) none_status_q <= STATUS_OVERFLOW;
		end
		if (load_emit) begin
			offset_q <= offset_q + LOAD_BITS'(cnt_q[lvl_q]);
			lvl_q    <= lvl_q + LVL_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_emit || load_none) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_emit) begin
			res_owner_q  <= RANK_W'(owner_q);
			res_offset_q <= OFFSET_W'(offset_q);
			res_level_q  <= lvl_q;
			res_last_q   <= emit_last;
			res_status_q <= STATUS_OK;
		end else if (load_none) begin
			res_owner_q  <= '1;
			res_offset_q <= '1;
			res_level_q  <= '0;
			res_last_q   <= 1'b1;
			res_status_q <= none_status_q;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.owner_rank   = res_owner_q;
	assign result.layer_offset = res_offset_q;
	assign result.level_index  = res_level_q;
	assign result.is_last      = res_last_q;
	assign result.status       = res_status_q;

endmodule
`default_nettype wire

@@ rtl/lloa_lane.sv @@
// One scan lane: holds the loads of every LANES-th owner and finds its minimum.
`default_nettype none
module lloa_lane (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [lloa_pkg::LANE_W-1:0] lane_id,
	input  wire logic                    clear,
	input  wire logic                    scan_start,
	input  wire logic [lloa_pkg::CFG_W-1:0]  owners,
	input  wire lloa_pkg::lloa_wr_t      wr,
	output lloa_pkg::lloa_cand_t         best
);
	import lloa_pkg::*;

	logic [LOAD_BITS-1:0] load_q [SLOTS];
	logic [SLOT_W-1:0]    slot_q;
	logic                 active_q;
	logic                 found_q;
	logic [OWNER_W-1:0]   best_idx_q;
	logic [LOAD_BITS-1:0] best_load_q;

	logic [OWNER_W-1:0]   cur_idx;
	logic                 in_range;
	logic                 take;

	// Owner held in the slot under scan
	assign cur_idx  = {slot_q, lane_id};
	assign in_range = CFG_W'(cur_idx) < owners;
	assign take     = active_q && in_range &&
		(!found_q || (load_q[slot_q] < best_load_q));

	// Owner loads: batch clear wins over a pending update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) load_q[i] <= '0;
		end else if (clear) begin
			for (int i = 0; i < SLOTS; i++) load_q[i] <= '0;
		end else if (wr.en && (wr.idx[LANE_W-1:0] == lane_id)) begin
			load_q[wr.idx[OWNER_W-1:LANE_W]] <= wr.data;
		end
	end

	// Walk the slots in ascending owner order; strict less keeps the lowest index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			slot_q   <= '0;
			found_q  <= 1'b0;
		end else if (scan_start) begin
			active_q <= 1'b1;
			slot_q   <= '0;
			found_q  <= 1'b0;
		end else if (active_q) begin
			slot_q <= slot_q + SLOT_W'(1);
			if (slot_q == SLOT_W'(SLOTS - 1)) active_q <= 1'b0;
			if (take) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= cur_idx;
			best_load_q <= load_q[slot_q];
		end
	end

	assign best = '{found: found_q, idx: best_idx_q, load: best_load_q};

endmodule
`default_nettype wire

@@ rtl/lloa_merge.sv @@
// Two-level registered tree that picks the least-loaded owner across lanes.
`default_nettype none
module lloa_merge (
	input  wire logic            clk,
	input  lloa_pkg::lloa_cand_t lane_best [lloa_pkg::LANES],
	output lloa_pkg::lloa_cand_t best
);
	import lloa_pkg::*;

	lloa_cand_t pair_s1 [LANES/2];
	lloa_cand_t best_s2;

	// Smaller load wins; equal loads go to the lower owner index
	function automatic lloa_cand_t pick(input lloa_cand_t a, input lloa_cand_t b);
		logic b_wins;
		b_wins = b.found && (!a.found || (b.load < a.load) ||
			((b.load == a.load) && (b.idx < a.idx)));
		return b_wins ? b : a;
	endfunction

	always_ff @(posedge clk) begin
		for (int k = 0; k < LANES/2; k++) begin
			pair_s1[k] <= pick(lane_best[2*k], lane_best[2*k+1]);
		end
		best_s2 <= pick(pair_s1[0], pair_s1[1]);
	end

	assign best = best_s2;

endmodule
`default_nettype wire

@@ rtl/lloa_checker.sv @@
// Port-level checker of the least-loaded owner assigner, bound to the top level.
`default_nettype none
`include "least_loaded_owner_assigner_assert.svh"
module lloa_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          item_valid,
	input wire logic                          item_ready,
	input wire logic                          res_valid,
	input wire logic                          res_ready,
	input wire logic [lloa_pkg::RANK_W-1:0]   owner_rank,
	input wire logic [lloa_pkg::OFFSET_W-1:0] layer_offset,
	input wire logic [lloa_pkg::LVL_W-1:0]    level_index,
	input wire logic                          is_last,
	input wire logic [lloa_pkg::STATUS_W-1:0] status
);
	import lloa_pkg::*;

	// A stalled result word stays valid and holds its owner, offset and status
	`LLOA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(owner_rank) && $stable(layer_offset) && $stable(status), "result word changed while stalled")

	// No owner means one closing word with no offset
	`LLOA_ASSERT_NOW(a_no_owner_shape, res_valid && (owner_rank == '1), (layer_offset == '1) && is_last && (level_index == '0), "ownerless word malformed")

	// Error words carry no owner
	`LLOA_ASSERT_NOW(a_err_no_owner, res_valid && (status != STATUS_OK), owner_rank == '1, "error word has an owner")

	// One surface in flight: input closes after each accept
	`LLOA_ASSERT_NEXT(a_one_in_flight, item_valid && item_ready, !item_ready, "second surface taken while busy")

endmodule

bind least_loaded_owner_assigner lloa_checker u_lloa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.owner_rank   (result.owner_rank),
	.layer_offset (result.layer_offset),
	.level_index  (result.level_index),
	.is_last      (result.is_last),
	.status       (result.status)
);
`default_nettype wire

@@ tb/owner_placement_check.sv @@
// Checker for the least-loaded owner assigner: predicts each result word and compares it.
`timescale 1ns / 1ps
module owner_placement_check (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [lloa_pkg::CFG_W-1:0] cfg_wdata,
	lloa_item_if                            item,
	lloa_result_if                          result,
	output int                              fail_count,
	output int                              pending,
	output int                              words_checked,
	output int                              retired_words,
	output int                              invalid_words,
	output int                              overflow_words
);
	import lloa_pkg::*;

	// One predicted result word
	typedef struct packed {
		logic signed [RANK_W-1:0]   owner_rank;
		logic signed [OFFSET_W-1:0] layer_offset;
		logic [LVL_W-1:0]           level_index;
		logic                       is_last;
		logic [STATUS_W-1:0]        status;
	} placement_t;

	logic [LOAD_BITS-1:0] owner_load [MAX_OWNERS];
	logic [CFG_W-1:0]     owner_count;
	placement_t           placement_q [$];

	// Single word for a surface that gets no owner
	function automatic placement_t no_owner(input logic [STATUS_W-1:0] code);
		placement_t w;
		w.owner_rank   = '1;
		w.layer_offset = '1;
		w.level_index  = '0;
		w.is_last      = 1'b1;
		w.status       = code;
		return w;
	endfunction

	// Pick the least-loaded owner, queue one word per layer, then charge the owner; a rejected surface queues one word
	task automatic place_surface(input logic batch_start, input logic is_retired,
			input logic [LEVEL_W-1:0] levels,
			input logic [MAX_LAYERS-1:0][COUNT_W-1:0] counts);
		int                  i;
		int                  owners;
		int                  best;
		logic                bad;
		logic [TOTAL_W-1:0]  total;
		logic [SUM_W-1:0]    new_load;
		logic [OFFSET_W-1:0] offset;
		placement_t          w;
		// a batch start clears the loads even for retired or bad surfaces
		if (batch_start) begin
			for (i = 0; i < MAX_OWNERS; i++)
				owner_load[i] = '0;
		end
		if (is_retired) begin
			placement_q = {placement_q, no_owner(STATUS_OK)};
			return;
		end
		bad = (levels == 0) || (levels > MAX_LAYERS);
		total = '0;
		if (!bad) begin
			for (i = 0; i < levels; i++) begin
				if (counts[i] == '0)
					bad = 1'b1;
				total += counts[i];
			end
		end
		if (bad) begin
			placement_q = {placement_q, no_owner(STATUS_INVALID)};
			return;
		end
		// clamp the owner count, then scan with ties to the lowest index
		owners = (owner_count == 0) ? 1 :
			(owner_count > MAX_OWNERS) ? MAX_OWNERS : int'(owner_count);
		best = 0;
		for (i = 1; i < owners; i++)
			if (owner_load[i] < owner_load[best])
				best = i;
		new_load = owner_load[best] + total;
		if (new_load[LOAD_BITS]) begin
			placement_q = {placement_q, no_owner(STATUS_OVERFLOW)};
			return;
		end
		offset = owner_load[best];
		for (i = 0; i < levels; i++) begin
			w.owner_rank   = RANK_W'(best);
			w.layer_offset = offset;
			w.level_index  = LVL_W'(i);
			w.is_last      = (i == levels - 1);
			w.status       = STATUS_OK;
			placement_q = {placement_q, w};
			offset += counts[i];
		end
		owner_load[best] = new_load[LOAD_BITS-1:0];
	endtask

	function automatic void compare_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Match the word on the result channel against the oldest prediction
	task automatic check_word();
		placement_t w;
		words_checked++;
		if (result.status == STATUS_INVALID)
			invalid_words++;
		else if (result.status == STATUS_OVERFLOW)
			overflow_words++;
		else if (result.owner_rank == '1)
			retired_words++;
		if (placement_q.size() == 0) begin
			$error("result word with nothing pending: owner_rank %0d, status %0d",
				result.owner_rank, result.status);
			fail_count++;
			return;
		end
		w = placement_q.pop_front();
		compare_field("owner_rank", w.owner_rank, result.owner_rank);
		compare_field("layer_offset", w.layer_offset, result.layer_offset);
		compare_field("level_index", w.level_index, result.level_index);
		compare_field("is_last", w.is_last, result.is_last);
		compare_field("status", w.status, result.status);
	endtask

	// Track config, predict on every accepted surface word, check every result word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_OWNERS; i++)
				owner_load[i] = '0;
			owner_count = CFG_W'(1);
			placement_q.delete();
			pending = 0;
		end else begin
			if (result.valid && result.ready)
				check_word();
			if (cfg_we)
				owner_count = cfg_wdata;
			if (item.valid && item.ready)
				place_surface(item.batch_start, item.is_retired, item.level_count,
					{item.layer3_count, item.layer2_count, item.layer1_count,
					item.layer0_count});
			pending = placement_q.size();
		end
	end

endmodule

@@ tb/least_loaded_owner_assigner_tb.sv @@
// Top of the owner assigner testbench: clock, reset, surface stimulus and verdict.
`timescale 1ns / 1ps
module least_loaded_owner_assigner_tb;
	import lloa_pkg::*;

	localparam int CLK_HALF        = 2;
	localparam int CYCLE_LIMIT     = 200_000;
	localparam int RANDOM_SURFACES = 341;
	localparam int SEGMENT_LEN     = 31;
	localparam int SETTLE_CYCLES   = 16;
	localparam logic [COUNT_W-1:0] CMAX = '1;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	int send_idle_pct;
	int recv_idle_pct;
	int cycles;
	int surfaces_sent;
	int settings_used;
	int fail_count;
	int pending;
	int words_checked;
	int retired_words;
	int invalid_words;
	int overflow_words;

	lloa_item_if   item_ch();
	lloa_result_if result_ch();

	least_loaded_owner_assigner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	owner_placement_check placement_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.item           (item_ch),
		.result         (result_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.words_checked  (words_checked),
		.retired_words  (retired_words),
		.invalid_words  (invalid_words),
		.overflow_words (overflow_words)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// Stall the result channel at the current rate
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	// Hard stop on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d result words pending", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [MAX_LAYERS-1:0][COUNT_W-1:0] layer_set(
			input logic [COUNT_W-1:0] c0, input logic [COUNT_W-1:0] c1,
			input logic [COUNT_W-1:0] c2, input logic [COUNT_W-1:0] c3);
		return {c3, c2, c1, c0};
	endfunction

	// Drop valid and put noise on the payload
	task automatic drive_idle_item();
		item_ch.valid        <= 1'b0;
		item_ch.batch_start  <= 1'($urandom);
		item_ch.is_retired   <= 1'($urandom);
		item_ch.level_count  <= LEVEL_W'($urandom);
		item_ch.layer0_count <= COUNT_W'($urandom);
		item_ch.layer1_count <= COUNT_W'($urandom);
		item_ch.layer2_count <= COUNT_W'($urandom);
		item_ch.layer3_count <= COUNT_W'($urandom);
	endtask

	// Offer one surface word and hold it until the handshake
	task automatic send_surface(input logic bs, input logic ret,
			input logic [LEVEL_W-1:0] lv,
			input logic [MAX_LAYERS-1:0][COUNT_W-1:0] counts);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			drive_idle_item();
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.batch_start  <= bs;
		item_ch.is_retired   <= ret;
		item_ch.level_count  <= lv;
		item_ch.layer0_count <= counts[0];
		item_ch.layer1_count <= counts[1];
		item_ch.layer2_count <= counts[2];
		item_ch.layer3_count <= counts[3];
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		surfaces_sent++;
	endtask

	// Hold the sender until every predicted word has come back
	task automatic drain_results();
		drive_idle_item();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_owner_count(input logic [CFG_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings_used++;
	endtask

	// Mostly well-formed surfaces, with retired, bad-level and zero-layer noise
	task automatic send_random_surface();
		logic [MAX_LAYERS-1:0][COUNT_W-1:0] counts;
		logic [LEVEL_W-1:0]                 lv;
		logic                               bs;
		logic                               ret;
		int                                 kind;
		int                                 i;
		kind = $urandom_range(99, 0);
		bs   = ($urandom_range(99, 0) < 6);
		ret  = (kind < 8);
		lv   = LEVEL_W'($urandom_range(MAX_LAYERS, 1));
		for (i = 0; i < MAX_LAYERS; i++) begin
			case ($urandom_range(3, 0))
				0: counts[i] = COUNT_W'($urandom_range(4, 1));
				1: counts[i] = COUNT_W'($urandom);
				2: counts[i] = CMAX;
				default: counts[i] = COUNT_W'($urandom_range(300, 1));
			endcase
			if (i >= lv && $urandom_range(3, 0) == 0)
				counts[i] = '0;
		end
		if (ret) begin
			lv = LEVEL_W'($urandom_range(7, 0));
		end else if (kind < 12) begin
			lv = LEVEL_W'($urandom_range(3, 0));
			if (lv != 0)
				lv = lv + LEVEL_W'(MAX_LAYERS);
		end else if (kind < 16) begin
			counts[$urandom_range(lv - 1, 0)] = '0;
		end
		send_surface(bs, ret, lv, counts);
	endtask

	initial begin
		int i;
		int seg;
		logic [CFG_W-1:0] settings [12];
		settings = '{5'd16, 5'd3, 5'd1, 5'd7, 5'd0, 5'd17, 5'd31, 5'd2, 5'd12, 5'd5,
			5'd16, 5'd4};
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		item_ch.valid        <= 1'b0;
		item_ch.batch_start  <= 1'b0;
		item_ch.is_retired   <= 1'b0;
		item_ch.level_count  <= '0;
		item_ch.layer0_count <= '0;
		item_ch.layer1_count <= '0;
		item_ch.layer2_count <= '0;
		item_ch.layer3_count <= '0;
		send_idle_pct = 17;
		recv_idle_pct = 49;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one owner after reset, field extremes and the retired and invalid reject paths
		send_surface(1'b0, 1'b0, 3'd1, layer_set(20'd1, 20'd0, 20'd0, 20'd0));
		send_surface(1'b0, 1'b0, 3'd4, layer_set(CMAX, CMAX, CMAX, CMAX));
		send_surface(1'b0, 1'b0, 3'd2, layer_set(20'd3, 20'd7, 20'h12345, 20'hABCDE));
		send_surface(1'b0, 1'b0, 3'd3, layer_set(20'd5, CMAX, 20'd1, CMAX));
		send_surface(1'b1, 1'b1, 3'd4, layer_set(CMAX, CMAX, CMAX, CMAX));
		send_surface(1'b0, 1'b1, 3'd0, layer_set(20'd0, 20'd0, 20'd0, 20'd0));
		send_surface(1'b0, 1'b0, 3'd0, layer_set(20'd1, 20'd1, 20'd1, 20'd1));
		send_surface(1'b0, 1'b0, 3'd5, layer_set(20'd1, 20'd1, 20'd1, 20'd1));
		send_surface(1'b0, 1'b0, 3'd6, layer_set(20'd2, 20'd2, 20'd2, 20'd2));
		send_surface(1'b0, 1'b0, 3'd7, layer_set(CMAX, CMAX, CMAX, CMAX));
		send_surface(1'b0, 1'b0, 3'd1, layer_set(20'd0, 20'd1, 20'd1, 20'd1));
		send_surface(1'b0, 1'b0, 3'd4, layer_set(20'd1, 20'd1, 20'd1, 20'd0));
		send_surface(1'b1, 1'b0, 3'd7, layer_set(20'd1, 20'd1, 20'd1, 20'd1));
		send_surface(1'b0, 1'b0, 3'd2, layer_set(20'd9, 20'd9, 20'd0, 20'd0));
		send_surface(1'b1, 1'b0, 3'd1, layer_set(20'd2, 20'd0, 20'd0, 20'd0));

		// Directed: spread over owners, ties to the lowest index, clamped counts
		write_owner_count(5'd31);
		send_surface(1'b1, 1'b0, 3'd1, layer_set(20'd5, 20'd0, 20'd0, 20'd0));
		send_surface(1'b0, 1'b0, 3'd2, layer_set(20'd2, 20'd3, 20'd0, 20'd0));
		send_surface(1'b0, 1'b0, 3'd1, layer_set(CMAX, 20'd0, 20'd0, 20'd0));
		send_surface(1'b0, 1'b0, 3'd4, layer_set(20'd1, 20'd1, 20'd1, 20'd1));
		write_owner_count(5'd0);
		send_surface(1'b0, 1'b0, 3'd1, layer_set(20'd1, 20'd0, 20'd0, 20'd0));
		write_owner_count(5'd17);
		send_surface(1'b0, 1'b0, 3'd1, layer_set(20'd1, 20'd0, 20'd0, 20'd0));

		// Random segments, one owner_count setting each; idling shifts by thirds
		for (seg = 0; seg < RANDOM_SURFACES / SEGMENT_LEN; seg++) begin
			write_owner_count(settings[seg]);
			for (i = 0; i < SEGMENT_LEN; i++) begin
				if (seg * SEGMENT_LEN + i < RANDOM_SURFACES / 3) begin
					send_idle_pct = 17;
					recv_idle_pct = 49;
				end else if (seg * SEGMENT_LEN + i < 2 * RANDOM_SURFACES / 3) begin
					send_idle_pct = 49;
					recv_idle_pct = 17;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				if (i == SEGMENT_LEN / 2 && seg == 1)
					drain_results();
				send_random_surface();
			end
		end

		// Stack full surfaces on a single owner, then split across two
		write_owner_count(5'd1);
		send_surface(1'b1, 1'b0, 3'd4, layer_set(CMAX, CMAX, CMAX, CMAX));
		send_surface(1'b0, 1'b0, 3'd1, layer_set(CMAX, 20'd0, 20'd0, 20'd0));
		send_surface(1'b0, 1'b0, 3'd1, layer_set(20'd1, 20'd0, 20'd0, 20'd0));
		send_surface(1'b0, 1'b1, 3'd1, layer_set(20'd1, 20'd0, 20'd0, 20'd0));
		send_surface(1'b0, 1'b0, 3'd4, layer_set(CMAX, CMAX, CMAX, CMAX));
		write_owner_count(5'd2);
		send_surface(1'b0, 1'b0, 3'd2, layer_set(20'd1, 20'd4, 20'd0, 20'd0));
		send_surface(1'b1, 1'b0, 3'd1, layer_set(20'd1, 20'd0, 20'd0, 20'd0));
		drain_results();

		$display("Sent %0d surfaces under %0d owner_count settings, with mixed stalls.",
			surfaces_sent, settings_used);
		$display("Checked %0d result words: %0d retired, %0d invalid, %0d overflow.",
			words_checked, retired_words, invalid_words, overflow_words);
		if (pending != 0)
			$error("%0d predicted result words never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lloa_pkg.sv
rtl/lloa_if.sv
rtl/lloa_lane.sv
rtl/lloa_merge.sv
rtl/least_loaded_owner_assigner.sv
rtl/lloa_checker.sv
tb/owner_placement_check.sv
tb/least_loaded_owner_assigner_tb.sv
